[rtl/core/sst_pkg.sv]
// ============================================================================
// sst_pkg
// Shared types and codes for the scoped symbol table: the item structs of
// both channels, request and status codes, controller states and the
// command/status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package sst_pkg;

    // Request codes carried in the mode field of an input item.
    typedef enum logic [2:0] {
        MODE_OPEN    = 3'd0,
        MODE_CLOSE   = 3'd1,
        MODE_DECLARE = 3'd2,
        MODE_LOOKUP  = 3'd3,
        MODE_ASSIGN  = 3'd4
    } t_mode;

    // Status codes returned with every result item.
    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_UNDECLARED = 3'd1,
        STAT_GLOBAL     = 3'd2,
        STAT_FULL       = 3'd3,
        STAT_DEPTH_OVF  = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]         mode;
        logic [31:0]        name_key;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [2:0]         status;
        logic [3:0]         scope_level;
    } t_out_item;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the accepted item, restart the scan
        logic clr_wr;   // write an empty entry during the reset sweep
        logic scan_rd;  // read the entry at the scan address and advance
        logic finish;   // apply the request and load the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;  // the item on the input needs a pass over the store
        logic addr_last;  // the scan address is the last entry
        logic out_free;   // the output register can take a result this cycle
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/core/sst_ram.sv]
// ============================================================================
// sst_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
`default_nettype none

module sst_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/core/sst_ctrl.sv]
// ============================================================================
// sst_ctrl
// Controller of the scoped symbol table: reset sweep, item acceptance,
// scan over the entry store and hand-off of the result.
// ============================================================================
`default_nettype none

module sst_ctrl import sst_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire t_dp_status i_status,
    output logic            o_in_stall,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.addr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = i_status.need_scan ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                if (i_status.addr_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_DONE: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

    // An accepted item always moves the controller out of idle.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> (r_state != ST_IDLE))
        else $error("accepted item did not start work");

    // The scan ends in the drain state before the result is applied.
    a_scan_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_status.addr_last) |=> (r_state == ST_DRAIN))
        else $error("scan did not end in the drain state");

    // The reset sweep never overlaps a scan read.
    a_no_scan_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr_wr |-> !o_cmd.scan_rd && !o_cmd.finish)
        else $error("sweep write overlaps request work");

endmodule

`default_nettype wire

[rtl/core/sst_dp.sv]
// ============================================================================
// sst_dp
// Datapath of the scoped symbol table: entry store, scan trackers, scope
// depth register and output register.
// ============================================================================
`default_nettype none

module sst_dp import sst_pkg::*; #(
    parameter int ENTRIES   = 64,
    parameter int MAX_DEPTH = 16,
    parameter int KEY_BITS  = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_in,
    input  wire t_dp_cmd   i_cmd,
    input  wire logic      i_out_stall,
    output t_dp_status     o_status,
    output logic           o_out_valid,
    output t_out_item      o_out
);

    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LVL_W = $clog2(MAX_DEPTH);
    localparam int LVL_X = (LVL_W > 4) ? LVL_W : 4;
    localparam int KW    = (KEY_BITS > 32) ? 32 : KEY_BITS;
    localparam int EW    = 1 + LVL_W + KW + 32;

    localparam logic [AW-1:0]    ADDR_LAST = AW'(ENTRIES - 1);
    localparam logic [LVL_W-1:0] DEPTH_TOP = LVL_W'(MAX_DEPTH - 1);

    typedef struct packed {
        logic             valid;
        logic [LVL_W-1:0] level;
        logic [KW-1:0]    key;
        logic [31:0]      value;
    } t_entry;

    // Request registers.
    logic [2:0]       r_mode;
    logic [KW-1:0]    r_key;
    logic [31:0]      r_val;

    // Scan control.
    logic [AW-1:0]    r_addr;
    logic [AW-1:0]    r_rd_idx;
    logic             r_rd_pend;
    logic [LVL_W-1:0] r_depth;

    // Trackers.
    logic             r_hit;
    logic [AW-1:0]    r_hit_idx;
    logic             r_free;
    logic [AW-1:0]    r_free_idx;
    logic             r_best;
    logic [AW-1:0]    r_best_idx;
    logic [LVL_W-1:0] r_best_lvl;
    logic [31:0]      r_best_val;

    // Output register.
    logic             r_out_valid;
    t_out_item        r_out;

    logic [EW-1:0]    w_rd_data;
    t_entry           rd_entry;
    logic             key_hit;
    logic             lvl_cur;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    t_entry           wr_entry;

    logic [LVL_W-1:0] n_depth;
    logic [31:0]      res_val;
    t_status          res_st;
    logic             fin_wr;
    logic [AW-1:0]    fin_idx;
    t_entry           fin_entry;
    logic [LVL_X-1:0] depth_x;

    sst_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    assign rd_entry = t_entry'(w_rd_data);
    assign key_hit  = rd_entry.valid && (rd_entry.key == r_key);
    assign lvl_cur  = (rd_entry.level == r_depth);

    // Close at global scope needs no scan; open and unknown codes neither.
    always_comb begin
        o_status.need_scan = 1'b0;
        case (i_in.mode)
            MODE_CLOSE:   o_status.need_scan = (r_depth != '0);
            MODE_DECLARE: o_status.need_scan = 1'b1;
            MODE_LOOKUP:  o_status.need_scan = 1'b1;
            MODE_ASSIGN:  o_status.need_scan = 1'b1;
            default:      o_status.need_scan = 1'b0;
        endcase
        o_status.addr_last = (r_addr == ADDR_LAST);
        o_status.out_free  = !r_out_valid || !i_out_stall;
    end

    // Outcome of the request once the scan is over.
    always_comb begin
        n_depth   = r_depth;
        res_val   = '0;
        res_st    = STAT_OK;
        fin_wr    = 1'b0;
        fin_idx   = r_hit_idx;
        fin_entry = '{valid: 1'b1, level: r_depth, key: r_key, value: r_val};
        case (r_mode)
            MODE_OPEN: begin
                if (r_depth == DEPTH_TOP) res_st = STAT_DEPTH_OVF;
                else n_depth = r_depth + 1'b1;
            end
            MODE_CLOSE: begin
                if (r_depth == '0) res_st = STAT_GLOBAL;
                else n_depth = r_depth - 1'b1;
            end
            MODE_DECLARE: begin
                if (r_hit) begin
                    fin_wr = 1'b1;
                end else if (r_free) begin
                    fin_wr  = 1'b1;
                    fin_idx = r_free_idx;
                end else begin
                    res_st = STAT_FULL;
                end
            end
            MODE_LOOKUP: begin
                if (r_best) res_val = r_best_val;
                else res_st = STAT_UNDECLARED;
            end
            MODE_ASSIGN: begin
                if (r_best) begin
                    fin_wr          = 1'b1;
                    fin_idx         = r_best_idx;
                    fin_entry.level = r_best_lvl;
                end else begin
                    res_st = STAT_UNDECLARED;
                end
            end
            default: begin
            end
        endcase
        depth_x = LVL_X'(n_depth);
    end

    // Store write port: reset sweep, close-scope invalidation, final update.
    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = r_addr;
        wr_entry = '0;
        if (i_cmd.clr_wr) begin
            wr_en = 1'b1;
        end else if (r_rd_pend && r_mode == MODE_CLOSE && rd_entry.valid && lvl_cur) begin
            wr_en   = 1'b1;
            wr_addr = r_rd_idx;
        end else if (i_cmd.finish && fin_wr) begin
            wr_en    = 1'b1;
            wr_addr  = fin_idx;
            wr_entry = fin_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_in.mode;
            r_key  <= i_in.name_key[KW-1:0];
            r_val  <= i_in.value;
        end
        r_rd_idx <= r_addr;
        if (r_rd_pend) begin
            if (key_hit && (!r_best || rd_entry.level > r_best_lvl)) begin
                r_best_idx <= r_rd_idx;
                r_best_lvl <= rd_entry.level;
                r_best_val <= rd_entry.value;
            end
            if (key_hit && lvl_cur && !r_hit) r_hit_idx <= r_rd_idx;
            if (!rd_entry.valid && !r_free) r_free_idx <= r_rd_idx;
        end
        if (i_cmd.finish) begin
            r_out.result_value <= res_val;
            r_out.status       <= res_st;
            r_out.scope_level  <= depth_x[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_rd_pend   <= 1'b0;
            r_depth     <= '0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_best      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.scan_rd;
            if (i_cmd.load) begin
                r_addr <= '0;
            end else if (i_cmd.scan_rd || i_cmd.clr_wr) begin
                r_addr <= r_addr + 1'b1;
            end
            if (i_cmd.load) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
                r_best <= 1'b0;
            end else if (r_rd_pend) begin
                if (key_hit && lvl_cur) r_hit <= 1'b1;
                if (!rd_entry.valid) r_free <= 1'b1;
                if (key_hit) r_best <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_depth     <= n_depth;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The scope depth stays inside the stack.
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_TOP)
        else $error("scope depth beyond the deepest level");

    // A request is applied only after the last scanned entry was evaluated.
    a_finish_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !r_rd_pend && !i_cmd.scan_rd)
        else $error("request applied while the scan is still running");

    // Applying a request always presents a result on the next cycle.
    a_finish_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("applied request produced no result");

endmodule

`default_nettype wire

[rtl/core/scoped_symbol_table.sv]
// ============================================================================
// scoped_symbol_table
// Nested-scope symbol table: open, close, declare, look up and assign over
// one shared store of entries, one result item for every request item.
// ============================================================================
// Flow: open, close at global scope and unknown codes go from idle straight to
//   the done state; every other request scans each entry and drains the last
//   read first. One item is handled at a time, since a request that scans
//   holds the single read port of the entry store.
// Reset: depth returns to the global scope, then a sweep over every entry
//   empties the store while input stays stalled.
`default_nettype none

module scoped_symbol_table import sst_pkg::*; #(
    parameter int ENTRIES   = 64,
    parameter int MAX_DEPTH = 16,
    parameter int KEY_BITS  = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // Request channel.
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in,
    // Result channel.
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out
);

    // The controller sequences each request: it accepts an item only in its
    // idle state, walks the scan address over every entry for requests that
    // must search the store, waits in the drain state for the last registered read,
    // and finally tells the datapath to apply the request and load the
    // output register. The output register lets the next item be accepted
    // while an earlier result still waits to be taken.
    t_dp_cmd    cmd;
    t_dp_status status;

    sst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // The datapath keeps the entry store in a RAM. Each scanned entry is
    // checked against the request: the first entry of the same name at the
    // current level and the first free entry serve a declare, the deepest
    // entry of that name serves look up and assign, and a close clears
    // every entry of the current level as it passes.
    sst_dp #(
        .ENTRIES   (ENTRIES),
        .MAX_DEPTH (MAX_DEPTH),
        .KEY_BITS  (KEY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
